[rtl/plrd_pkg.sv]
// Shared constants, codes and types of the line RLE image decoder.
package plrd_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int GROUP_PIXELS = 16;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int POS_W        = 11;
   localparam int WORD_W       = 24;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_ORG_X  = 3'd2;
   localparam logic [2:0] REG_ORG_Y  = 3'd3;
   localparam logic [2:0] REG_TRANS  = 3'd4;
   localparam logic [2:0] REG_KEY    = 3'd5;
   localparam logic [2:0] REG_DRAW   = 3'd6;

   localparam logic [7:0] CODE_ABOVE = 8'hFF;
   localparam logic [7:0] CODE_TWO   = 8'hFE;
   localparam logic [7:0] CODE_FILL  = 8'hFD;
   localparam logic [7:0] CODE_PAIR  = 8'hFC;
   localparam logic [7:0] CODE_ESC_HI = 8'hFB;
   localparam logic [7:0] CODE_ESC_LO = 8'hF8;

   localparam logic [1:0] SRC_ABOVE = 2'd0;
   localparam logic [1:0] SRC_TWO   = 2'd1;
   localparam logic [1:0] SRC_FILL  = 2'd2;
   localparam logic [1:0] SRC_PAIR  = 2'd3;

   typedef struct packed {
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic        transparency_on;
      logic [7:0]  key_index;
      logic        draw_enable;
   } cfg_type;

   typedef struct packed {
      logic [10:0] column;
      logic [10:0] row;
      logic [63:0] pixels_low;
      logic [63:0] pixels_high;
      logic [4:0]  pixel_count;
      logic [15:0] write_mask;
      logic        row_end;
      logic        image_end;
      logic        last;
   } rsp_type;

endpackage

[rtl/plrd_ifs.sv]
// Channel interfaces of the line RLE image decoder.
interface plrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       image_start;
   modport source (output valid, output code_byte, output image_start, input ready);
   modport sink (input valid, input code_byte, input image_start, output ready);
endinterface

interface plrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] column;
   logic [10:0] row;
   logic [63:0] pixels_low;
   logic [63:0] pixels_high;
   logic [4:0]  pixel_count;
   logic [15:0] write_mask;
   logic        row_end;
   logic        image_end;
   logic        last;
   modport source (output valid, output column, output row, output pixels_low,
                   output pixels_high, output pixel_count, output write_mask,
                   output row_end, output image_end, output last, input ready);
   modport sink (input valid, input column, input row, input pixels_low,
                 input pixels_high, input pixel_count, input write_mask,
                 input row_end, input image_end, input last, output ready);
endinterface

interface plrd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [10:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/plrd_ram.sv]
// Generic single-port-write, registered-read RAM.
module plrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/plrd_csr.sv]
// Configuration register file of the line RLE image decoder.
module plrd_csr (
   input  logic               clock,
   input  logic               reset,
   plrd_csr_if.sink           csr_ch,
   output plrd_pkg::cfg_type  cfg
);
   plrd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            plrd_pkg::REG_WIDTH:  cfg_in.image_width = csr_ch.data;
            plrd_pkg::REG_HEIGHT: cfg_in.image_height = csr_ch.data;
            plrd_pkg::REG_ORG_X:  cfg_in.origin_x = csr_ch.data[9:0];
            plrd_pkg::REG_ORG_Y:  cfg_in.origin_y = csr_ch.data[9:0];
            plrd_pkg::REG_TRANS:  cfg_in.transparency_on = csr_ch.data[0];
            plrd_pkg::REG_KEY:    cfg_in.key_index = csr_ch.data[7:0];
            plrd_pkg::REG_DRAW:   cfg_in.draw_enable = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= 11'd640;
         cfg_ff.image_height    <= 11'd400;
         cfg_ff.origin_x        <= '0;
         cfg_ff.origin_y        <= '0;
         cfg_ff.transparency_on <= 1'b0;
         cfg_ff.key_index       <= '0;
         cfg_ff.draw_enable     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;
endmodule

[rtl/plrd_ctrl.sv]
// Parser and run sequencer: read-modify-write of the line history memory.
module plrd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  plrd_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   input  logic [7:0]                    req_code,
   input  logic                          req_start,
   output logic                          req_ready,
   output logic                          ram_wr_en,
   output logic [plrd_pkg::ADDR_W-1:0]   ram_wr_addr,
   output logic [plrd_pkg::WORD_W-1:0]   ram_wr_data,
   output logic                          ram_rd_en,
   output logic [plrd_pkg::ADDR_W-1:0]   ram_rd_addr,
   input  logic [plrd_pkg::WORD_W-1:0]   ram_rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output plrd_pkg::rsp_type             rsp
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_PARSE  = 4'd2;
   localparam logic [3:0] S_START  = 4'd3;
   localparam logic [3:0] S_RD     = 4'd4;
   localparam logic [3:0] S_WR     = 4'd5;
   localparam logic [3:0] S_EMIT   = 4'd6;
   localparam logic [3:0] S_RUNEND = 4'd7;
   localparam logic [3:0] S_SHIFT  = 4'd8;
   localparam logic [3:0] S_ROWEND = 4'd9;

   localparam logic [2:0] PH_CODE   = 3'd0;
   localparam logic [2:0] PH_COPY_N = 3'd1;
   localparam logic [2:0] PH_FILL_N = 3'd2;
   localparam logic [2:0] PH_FILL_B = 3'd3;
   localparam logic [2:0] PH_PAIR_N = 3'd4;
   localparam logic [2:0] PH_PAIR_A = 3'd5;
   localparam logic [2:0] PH_PAIR_B = 3'd6;
   localparam logic [2:0] PH_ESC    = 3'd7;

   localparam int PW = plrd_pkg::POS_W;
   localparam logic [PW-1:0] CLEAR_LAST = PW'(plrd_pkg::MAX_WIDTH - 1);
   localparam logic [PW-1:0] MAXW = PW'(plrd_pkg::MAX_WIDTH);
   localparam logic [4:0] GROUP_N = 5'(plrd_pkg::GROUP_PIXELS);

   logic [3:0]    state_ff, state_in;
   logic          pend_ff, pend_in;
   logic [7:0]    byte_ff, byte_in;
   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    code_ff, code_in;
   logic [8:0]    len_ff, len_in;
   logic [7:0]    first_ff, first_in;
   logic [PW-1:0] col_ff, col_in;
   logic [PW-1:0] row_ff, row_in;
   logic          done_ff, done_in;
   logic [1:0]    kind_ff, kind_in;
   logic [9:0]    n_ff, n_in;
   logic [7:0]    a_ff, a_in;
   logic [7:0]    b_ff, b_in;
   logic [PW-1:0] take_ff, take_in;
   logic          erow_ff, erow_in;
   logic          eimg_ff, eimg_in;
   logic [PW-1:0] i_ff, i_in;
   logic [PW-1:0] gs_ff, gs_in;
   logic [4:0]    gcnt_ff, gcnt_in;
   logic [127:0]  pix_ff, pix_in;
   logic [15:0]   mask_ff, mask_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   plrd_pkg::rsp_type rsp_ff, rsp_in;

   logic [PW-1:0] eff_w, eff_h, room, take_c;
   logic [PW:0]   col_take, row_next;
   logic [7:0]    pix_v;
   logic [PW-1:0] x_sum;

   always_comb begin
      if (cfg.image_width == '0) begin
         eff_w = PW'(1);
      end else if (cfg.image_width > MAXW) begin
         eff_w = MAXW;
      end else begin
         eff_w = cfg.image_width;
      end
      eff_h = (cfg.image_height == '0) ? PW'(1) : cfg.image_height;
      room = eff_w - col_ff;
      take_c = ({1'b0, n_ff} < room) ? {1'b0, n_ff} : room;
      col_take = {1'b0, col_ff} + {1'b0, take_c};
      row_next = {1'b0, row_ff} + (PW+1)'(1);
      x_sum = col_ff + i_ff;
      unique case (kind_ff)
         plrd_pkg::SRC_ABOVE: pix_v = ram_rd_data[15:8];
         plrd_pkg::SRC_TWO:   pix_v = ram_rd_data[7:0];
         plrd_pkg::SRC_FILL:  pix_v = a_ff;
         default:             pix_v = i_ff[0] ? b_ff : a_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff; pend_in = pend_ff; byte_in = byte_ff;
      phase_in = phase_ff; code_in = code_ff; len_in = len_ff; first_in = first_ff;
      col_in = col_ff; row_in = row_ff; done_in = done_ff;
      kind_in = kind_ff; n_in = n_ff; a_in = a_ff; b_in = b_ff;
      take_in = take_ff; erow_in = erow_ff; eimg_in = eimg_ff;
      i_in = i_ff; gs_in = gs_ff; gcnt_in = gcnt_ff; pix_in = pix_ff; mask_in = mask_ff;
      cnt_in = cnt_ff; rv_in = rv_ff; rsp_in = rsp_ff;
      ram_wr_en = 1'b0; ram_wr_addr = '0; ram_wr_data = '0;
      ram_rd_en = 1'b0; ram_rd_addr = '0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_code;
               if (req_start) begin
                  phase_in = PH_CODE; code_in = '0; len_in = '0; first_in = '0;
                  col_in = '0; row_in = '0; done_in = 1'b0;
                  pend_in = 1'b1; cnt_in = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_PARSE;
               end
            end
         end
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = cnt_ff[plrd_pkg::ADDR_W-1:0];
            cnt_in = cnt_ff + PW'(1);
            if (cnt_ff == CLEAR_LAST) begin
               state_in = pend_ff ? S_PARSE : S_IDLE;
               pend_in = 1'b0;
            end
         end
         S_PARSE: begin
            state_in = S_IDLE;
            if (!done_ff) begin
               unique case (phase_ff)
                  PH_CODE: begin
                     code_in = byte_ff;
                     if (byte_ff == plrd_pkg::CODE_ABOVE || byte_ff == plrd_pkg::CODE_TWO) begin
                        phase_in = PH_COPY_N;
                     end else if (byte_ff == plrd_pkg::CODE_FILL) begin
                        phase_in = PH_FILL_N;
                     end else if (byte_ff == plrd_pkg::CODE_PAIR) begin
                        phase_in = PH_PAIR_N;
                     end else if (byte_ff >= plrd_pkg::CODE_ESC_LO) begin
                        phase_in = PH_ESC;
                     end else begin
                        code_in = code_ff;
                        kind_in = plrd_pkg::SRC_FILL; n_in = 10'd1; a_in = byte_ff;
                        state_in = S_START;
                     end
                  end
                  PH_COPY_N: begin
                     phase_in = PH_CODE;
                     kind_in = (code_ff == plrd_pkg::CODE_ABOVE) ? plrd_pkg::SRC_ABOVE
                                                                 : plrd_pkg::SRC_TWO;
                     n_in = {2'b0, byte_ff} + 10'd3;
                     state_in = S_START;
                  end
                  PH_FILL_N: begin
                     len_in = {1'b0, byte_ff} + 9'd4;
                     phase_in = PH_FILL_B;
                  end
                  PH_FILL_B: begin
                     phase_in = PH_CODE;
                     kind_in = plrd_pkg::SRC_FILL; n_in = {1'b0, len_ff}; a_in = byte_ff;
                     state_in = S_START;
                  end
                  PH_PAIR_N: begin
                     len_in = {1'b0, byte_ff} + 9'd3;
                     phase_in = PH_PAIR_A;
                  end
                  PH_PAIR_A: begin
                     first_in = byte_ff;
                     phase_in = PH_PAIR_B;
                  end
                  PH_PAIR_B: begin
                     phase_in = PH_CODE;
                     kind_in = plrd_pkg::SRC_PAIR; n_in = {len_ff, 1'b0};
                     a_in = first_ff; b_in = byte_ff;
                     state_in = S_START;
                  end
                  default: begin
                     phase_in = PH_CODE;
                     kind_in = plrd_pkg::SRC_FILL; n_in = 10'd1; a_in = byte_ff;
                     state_in = S_START;
                  end
               endcase
            end
         end
         S_START: begin
            if (col_ff >= eff_w) begin
               cnt_in = '0;
               state_in = cfg.draw_enable ? S_SHIFT : S_ROWEND;
            end else begin
               take_in = take_c;
               erow_in = col_take >= {1'b0, eff_w};
               eimg_in = (col_take >= {1'b0, eff_w}) && (row_next >= {1'b0, eff_h});
               i_in = '0; gs_in = '0; gcnt_in = '0; pix_in = '0; mask_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            ram_rd_en = 1'b1;
            ram_rd_addr = x_sum[plrd_pkg::ADDR_W-1:0];
            state_in = S_WR;
         end
         S_WR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = x_sum[plrd_pkg::ADDR_W-1:0];
            ram_wr_data = {pix_v, ram_rd_data[15:0]};
            pix_in[{gcnt_ff[3:0], 3'b000} +: 8] = pix_v;
            mask_in[gcnt_ff[3:0]] = !(cfg.transparency_on && pix_v == cfg.key_index);
            gcnt_in = gcnt_ff + 5'd1;
            i_in = i_ff + PW'(1);
            if (i_in == take_ff || gcnt_in == GROUP_N) begin
               if (cfg.draw_enable) begin
                  state_in = S_EMIT;
               end else if (i_in == take_ff) begin
                  state_in = S_RUNEND;
               end else begin
                  gs_in = i_in; gcnt_in = '0; pix_in = '0; mask_in = '0;
                  state_in = S_RD;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               rsp_in.column = PW'({1'b0, cfg.origin_x}) + col_ff + gs_ff;
               rsp_in.row = PW'({1'b0, cfg.origin_y}) + row_ff;
               rsp_in.pixels_low = pix_ff[63:0];
               rsp_in.pixels_high = pix_ff[127:64];
               rsp_in.pixel_count = gcnt_ff;
               rsp_in.write_mask = mask_ff;
               rsp_in.row_end = (i_ff == take_ff) && erow_ff;
               rsp_in.image_end = (i_ff == take_ff) && eimg_ff;
               rsp_in.last = (i_ff == take_ff);
               gs_in = i_ff; gcnt_in = '0; pix_in = '0; mask_in = '0;
               state_in = (i_ff == take_ff) ? S_RUNEND : S_RD;
            end
         end
         S_RUNEND: begin
            col_in = col_ff + take_ff;
            cnt_in = '0;
            if (erow_ff) begin
               state_in = cfg.draw_enable ? S_SHIFT : S_ROWEND;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (cnt_ff < eff_w) begin
               ram_rd_en = 1'b1;
               ram_rd_addr = cnt_ff[plrd_pkg::ADDR_W-1:0];
            end
            if (cnt_ff != '0) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = cnt_ff[plrd_pkg::ADDR_W-1:0] - plrd_pkg::ADDR_W'(1);
               ram_wr_data = {ram_rd_data[23:16], ram_rd_data[23:16], ram_rd_data[15:8]};
            end
            cnt_in = cnt_ff + PW'(1);
            if (cnt_ff == eff_w) begin
               state_in = S_ROWEND;
            end
         end
         S_ROWEND: begin
            col_in = '0;
            row_in = row_next[PW-1:0];
            if (row_next[PW-1:0] >= eff_h) begin
               done_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; pend_ff <= 1'b0; cnt_ff <= '0;
         phase_ff <= PH_CODE; code_ff <= '0; len_ff <= '0; first_ff <= '0;
         col_ff <= '0; row_ff <= '0; done_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pend_ff <= pend_in; cnt_ff <= cnt_in;
         phase_ff <= phase_in; code_ff <= code_in; len_ff <= len_in; first_ff <= first_in;
         col_ff <= col_in; row_ff <= row_in; done_ff <= done_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in; kind_ff <= kind_in; n_ff <= n_in; a_ff <= a_in; b_ff <= b_in;
      take_ff <= take_in; erow_ff <= erow_in; eimg_ff <= eimg_in;
      i_ff <= i_in; gs_ff <= gs_in; gcnt_ff <= gcnt_in; pix_ff <= pix_in;
      mask_ff <= mask_in; rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;
endmodule

[rtl/pms_line_rle_decoder.sv]
// Top level of the line RLE image decoder.
//  channel | dir | transfer payload
//  req_ch  | in  | code_byte, image_start
//  rsp_ch  | out | column, row, pixels_low/high, pixel_count, write_mask, flags
//  csr_ch  | in  | index, data
// A literal byte is parsed and decoded as a run of one pixel; a prefix or count byte is only parsed.
// A run reads and writes back each pixel in the line memory and, when drawing is enabled, emits each group.
// A completed row, when drawing is enabled, adds the history shift through the line memory.
// Reset and image_start each start a clearing pass over all 1024 words of the line memory.
// A stalled result holds the sequencer only when a second group is ready.
module pms_line_rle_decoder (
   input logic         clock,
   input logic         reset,
   plrd_req_if.sink    req_ch,
   plrd_rsp_if.source  rsp_ch,
   plrd_csr_if.sink    csr_ch
);
   plrd_pkg::cfg_type cfg;
   plrd_pkg::rsp_type rsp;
   logic                          wr_en, rd_en;
   logic [plrd_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
   logic [plrd_pkg::WORD_W-1:0]   wr_data, rd_data;

   plrd_csr u_csr (
      .clock(clock), .reset(reset), .csr_ch(csr_ch), .cfg(cfg)
   );

   plrd_ram #(.WIDTH(plrd_pkg::WORD_W), .DEPTH(plrd_pkg::MAX_WIDTH)) u_line_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   plrd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_ch.valid), .req_code(req_ch.code_byte),
      .req_start(req_ch.image_start), .req_ready(req_ch.ready),
      .ram_wr_en(wr_en), .ram_wr_addr(wr_addr), .ram_wr_data(wr_data),
      .ram_rd_en(rd_en), .ram_rd_addr(rd_addr), .ram_rd_data(rd_data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp(rsp)
   );

   assign rsp_ch.column      = rsp.column;
   assign rsp_ch.row         = rsp.row;
   assign rsp_ch.pixels_low  = rsp.pixels_low;
   assign rsp_ch.pixels_high = rsp.pixels_high;
   assign rsp_ch.pixel_count = rsp.pixel_count;
   assign rsp_ch.write_mask  = rsp.write_mask;
   assign rsp_ch.row_end     = rsp.row_end;
   assign rsp_ch.image_end   = rsp.image_end;
   assign rsp_ch.last        = rsp.last;
endmodule

[dv/pms_line_rle_decoder_checker.sv]
// Checker that predicts the decoded pixel groups and compares every result transfer.
module pms_line_rle_decoder_checker
   import plrd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   plrd_req_if   req_mon,
   plrd_rsp_if   rsp_mon,
   plrd_csr_if   csr_mon,
   output int    failures,
   output int    groups_pending
);

   localparam int PH_CODE   = 0;
   localparam int PH_COPY_N = 1;
   localparam int PH_FILL_N = 2;
   localparam int PH_FILL_B = 3;
   localparam int PH_PAIR_N = 4;
   localparam int PH_PAIR_A = 5;
   localparam int PH_PAIR_B = 6;
   localparam int PH_ESC    = 7;

   logic [7:0]  cur_line [MAX_WIDTH];
   logic [7:0]  above_line [MAX_WIDTH];
   logic [7:0]  two_line [MAX_WIDTH];
   int          parse_state;
   logic [7:0]  held_code;
   int          held_len;
   logic [7:0]  held_first;
   int          col_pos;
   int          row_pos;
   bit          img_done;
   cfg_type     cfg;
   rsp_type     expected_groups [$];

   assign groups_pending = expected_groups.size();

   task automatic clear_image();
      for (int x = 0; x < MAX_WIDTH; x++) begin
         cur_line[x] = 0;
         above_line[x] = 0;
         two_line[x] = 0;
      end
      parse_state = PH_CODE;
      held_code = 0;
      held_len = 0;
      held_first = 0;
      col_pos = 0;
      row_pos = 0;
      img_done = 0;
   endtask

   function automatic int width_now();
      int w;
      w = cfg.image_width;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int height_now();
      return (cfg.image_height == 0) ? 1 : int'(cfg.image_height);
   endfunction

   task automatic close_row(int w);
      if (cfg.draw_enable) begin
         for (int x = 0; x < w; x++) begin
            two_line[x] = above_line[x];
            above_line[x] = cur_line[x];
         end
      end
      col_pos = 0;
      row_pos = (row_pos + 1) & 11'h7FF;
      if (row_pos >= height_now()) img_done = 1;
   endtask

   task automatic decode_run(logic [1:0] src, int n, logic [7:0] a, logic [7:0] b);
      int      w, take, i, g, x, k, made;
      bit      ends_row, ends_img;
      logic [7:0] v;
      rsp_type grp;
      w = width_now();
      made = 0;
      if (col_pos >= w) begin
         close_row(w);
         return;
      end
      take = (n < w - col_pos) ? n : w - col_pos;
      ends_row = (col_pos + take >= w);
      ends_img = ends_row && (row_pos + 1 >= height_now());
      i = 0;
      while (i < take) begin
         g = (take - i > GROUP_PIXELS) ? GROUP_PIXELS : take - i;
         grp = '0;
         for (int j = 0; j < g; j++) begin
            x = (col_pos + i + j) % MAX_WIDTH;
            k = i + j;
            case (src)
               SRC_ABOVE: v = above_line[x];
               SRC_TWO:   v = two_line[x];
               SRC_FILL:  v = a;
               default:   v = k[0] ? b : a;
            endcase
            cur_line[x] = v;
            if (j < 8) grp.pixels_low[8*j +: 8] = v;
            else grp.pixels_high[8*(j-8) +: 8] = v;
            if (!(cfg.transparency_on && v == cfg.key_index)) grp.write_mask[j] = 1'b1;
         end
         if (cfg.draw_enable) begin
            grp.column = 11'(cfg.origin_x + col_pos + i);
            grp.row = 11'(cfg.origin_y + row_pos);
            grp.pixel_count = 5'(g);
            grp.row_end = (i + g == take) && ends_row;
            grp.image_end = (i + g == take) && ends_img;
            expected_groups.push_back(grp);
            made++;
         end
         i += g;
      end
      col_pos = col_pos + take;
      if (ends_row) close_row(w);
      if (made > 0) expected_groups[expected_groups.size()-1].last = 1'b1;
   endtask

   task automatic decode_byte(logic [7:0] c, logic start);
      if (start) clear_image();
      if (img_done) return;
      case (parse_state)
         PH_CODE: begin
            if (c == CODE_ABOVE || c == CODE_TWO) begin
               held_code = c;
               parse_state = PH_COPY_N;
            end else if (c == CODE_FILL) begin
               parse_state = PH_FILL_N;
            end else if (c == CODE_PAIR) begin
               parse_state = PH_PAIR_N;
            end else if (c >= CODE_ESC_LO && c <= CODE_ESC_HI) begin
               parse_state = PH_ESC;
            end else begin
               decode_run(SRC_FILL, 1, c, 8'h00);
            end
         end
         PH_COPY_N: begin
            parse_state = PH_CODE;
            decode_run(held_code == CODE_ABOVE ? SRC_ABOVE : SRC_TWO, c + 3, 8'h00, 8'h00);
         end
         PH_FILL_N: begin
            held_len = c + 4;
            parse_state = PH_FILL_B;
         end
         PH_FILL_B: begin
            parse_state = PH_CODE;
            decode_run(SRC_FILL, held_len, c, 8'h00);
         end
         PH_PAIR_N: begin
            held_len = c + 3;
            parse_state = PH_PAIR_A;
         end
         PH_PAIR_A: begin
            held_first = c;
            parse_state = PH_PAIR_B;
         end
         PH_PAIR_B: begin
            parse_state = PH_CODE;
            decode_run(SRC_PAIR, 2 * held_len, held_first, c);
         end
         default: begin
            parse_state = PH_CODE;
            decode_run(SRC_FILL, 1, c, 8'h00);
         end
      endcase
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.image_width = 640;
         cfg.image_height = 400;
         cfg.origin_x = 0;
         cfg.origin_y = 0;
         cfg.transparency_on = 0;
         cfg.key_index = 0;
         cfg.draw_enable = 1;
         clear_image();
         expected_groups.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_WIDTH:  cfg.image_width = csr_mon.data;
               REG_HEIGHT: cfg.image_height = csr_mon.data;
               REG_ORG_X:  cfg.origin_x = csr_mon.data[9:0];
               REG_ORG_Y:  cfg.origin_y = csr_mon.data[9:0];
               REG_TRANS:  cfg.transparency_on = csr_mon.data[0];
               REG_KEY:    cfg.key_index = csr_mon.data[7:0];
               REG_DRAW:   cfg.draw_enable = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.code_byte, req_mon.image_start);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_groups.size() == 0) begin
               $error("unexpected result transfer at column %0d row %0d",
                      rsp_mon.column, rsp_mon.row);
               failures++;
            end else begin
               want = expected_groups.pop_front();
               check_field("column", want.column, rsp_mon.column);
               check_field("row", want.row, rsp_mon.row);
               check_field("pixels_low", want.pixels_low, rsp_mon.pixels_low);
               check_field("pixels_high", want.pixels_high, rsp_mon.pixels_high);
               check_field("pixel_count", want.pixel_count, rsp_mon.pixel_count);
               check_field("write_mask", want.write_mask, rsp_mon.write_mask);
               check_field("row_end", want.row_end, rsp_mon.row_end);
               check_field("image_end", want.image_end, rsp_mon.image_end);
               check_field("last", want.last, rsp_mon.last);
            end
         end
      end
   end

   initial failures = 0;

endmodule

[dv/pms_line_rle_decoder_test.sv]
// Testbench top that drives code bytes and register writes and reports the verdict.
module pms_line_rle_decoder_test;
   import plrd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 3000;

   logic clock;
   logic reset;
   int   failures;
   int   groups_pending;
   int   cycles;
   bit   hold_rsp;
   bit   no_gaps;

   plrd_req_if req_ch ();
   plrd_rsp_if rsp_ch ();
   plrd_csr_if csr_ch ();

   pms_line_rle_decoder dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   pms_line_rle_decoder_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .failures      (failures),
      .groups_pending(groups_pending)
   );

   initial clock = 0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (1500) @(posedge clock);
            hold_rsp = 0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(logic [7:0] c, logic start);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.code_byte <= c;
      req_ch.image_start <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [10:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (groups_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(int w, int h, int ox, int oy, bit tr, int key, bit draw);
      drain();
      write_reg(REG_WIDTH, 11'(w));
      write_reg(REG_HEIGHT, 11'(h));
      write_reg(REG_ORG_X, 11'(ox));
      write_reg(REG_ORG_Y, 11'(oy));
      write_reg(REG_TRANS, 11'(tr));
      write_reg(REG_KEY, 11'(key));
      write_reg(REG_DRAW, 11'(draw));
   endtask

   function automatic logic [7:0] run_len();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 20));
   endfunction

   // One well-formed code with random content, or now and then a stray byte.
   task automatic send_code(logic start, ref int sent);
      int         r;
      logic [7:0] lit;
      r = $urandom_range(0, 99);
      lit = 8'($urandom_range(0, 8'hF7));
      if (r < 45) begin
         send_byte(lit, start);
         sent += 1;
      end else if (r < 53) begin
         send_byte(8'($urandom_range(CODE_ESC_LO, CODE_ESC_HI)), start);
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         sent += 2;
      end else if (r < 67) begin
         send_byte(r[0] ? CODE_ABOVE : CODE_TWO, start);
         send_byte(run_len(), 1'b0);
         sent += 2;
      end else if (r < 78) begin
         send_byte(CODE_FILL, start);
         send_byte(run_len(), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         sent += 3;
      end else if (r < 90) begin
         send_byte(CODE_PAIR, start);
         send_byte(run_len(), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         sent += 4;
      end else begin
         send_byte(8'($urandom_range(0, 255)), start);
         sent += 1;
      end
   endtask

   task automatic random_stream(int bytes, bit fresh);
      int sent;
      sent = 0;
      send_code(fresh, sent);
      while (sent < bytes) send_code($urandom_range(0, 40) == 0, sent);
   endtask

   initial begin
      int w, h;
      cycles = 0;
      hold_rsp = 0;
      no_gaps = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.code_byte <= 8'h00;
      req_ch.image_start <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_WIDTH;
      csr_ch.data <= 11'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(20, 4, 5, 7, 1, 8'hAA, 1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(CODE_ESC_LO, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CODE_ESC_HI, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hF9, 1'b0);
      send_byte(8'hFD, 1'b0);
      send_byte(CODE_FILL, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(CODE_ABOVE, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(CODE_TWO, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(CODE_PAIR, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(CODE_FILL, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);

      set_config(2047, 3, 1023, 1023, 0, 0, 1);
      no_gaps = 1;
      random_stream(40, 1);
      no_gaps = 0;

      // Narrow the row under the current column, then keep decoding the same image.
      set_config(3, 3, 1023, 1023, 1, 0, 1);
      random_stream(12, 0);

      set_config(0, 0, 0, 0, 0, 0, 1);
      random_stream(10, 1);

      set_config(6, 1024, 0, 512, 1, 255, 1);
      hold_rsp = 1;
      random_stream(40, 1);

      set_config(9, 4, 100, 3, 0, 0, 0);
      random_stream(25, 1);

      for (int p = 0; p < 9; p++) begin
         w = ($urandom_range(0, 6) == 0) ? $urandom_range(100, 2047) : $urandom_range(1, 24);
         h = $urandom_range(1, 8);
         set_config(w, h, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1), $urandom_range(0, 1) ? 0 : $urandom_range(0, 255),
                    $urandom_range(0, 7) != 0);
         no_gaps = (p % 3 == 0);
         random_stream(25, 1);
      end
      no_gaps = 0;

      drain();
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
